FILE: hdl/keyboard_scancode_line_editor_defines.svh
// Assertion macros shared by the checker of the keyboard line editor.
`ifndef KEYBOARD_SCANCODE_LINE_EDITOR_DEFINES_SVH
`define KEYBOARD_SCANCODE_LINE_EDITOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define KLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/kle_pkg.sv
// Package of the keyboard line editor: sizes, codes, key table and shared types.
`default_nettype none

package kle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

    localparam int CODE_W = 8;
    localparam int CHAR_W = 7;
    localparam int KIND_W = 2;

    // Scan codes with a meaning of their own.
    localparam logic [CODE_W-1:0] CODE_CAPS  = 8'h3A;
    localparam logic [CODE_W-1:0] CODE_BKSP  = 8'h0E;
    localparam logic [CODE_W-1:0] CODE_ENTER = 8'h1C;
    localparam logic [CODE_W-1:0] CODE_MAX   = 8'd57;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BKSP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STORED  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 7'd32;

    // Request from the sequencer to the line memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // US layout, set 1 make codes 0 to 57. Keys without a printable meaning give '?', but backspace and enter give 0.
    function automatic logic [CHAR_W-1:0] us_key(input logic [5:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            6'd0, 6'd1, 6'd15, 6'd29, 6'd42,
            6'd54, 6'd55, 6'd56: ch = 7'h3F;
            6'd2:  ch = 7'h31;
            6'd3:  ch = 7'h32;
            6'd4:  ch = 7'h33;
            6'd5:  ch = 7'h34;
            6'd6:  ch = 7'h35;
            6'd7:  ch = 7'h36;
            6'd8:  ch = 7'h37;
            6'd9:  ch = 7'h38;
            6'd10: ch = 7'h39;
            6'd11: ch = 7'h30;
            6'd12: ch = 7'h2D;
            6'd13: ch = 7'h3D;
            6'd16: ch = 7'h71;
            6'd17: ch = 7'h77;
            6'd18: ch = 7'h65;
            6'd19: ch = 7'h72;
            6'd20: ch = 7'h74;
            6'd21: ch = 7'h79;
            6'd22: ch = 7'h75;
            6'd23: ch = 7'h69;
            6'd24: ch = 7'h6F;
            6'd25: ch = 7'h70;
            6'd26: ch = 7'h5B;
            6'd27: ch = 7'h5D;
            6'd30: ch = 7'h61;
            6'd31: ch = 7'h73;
            6'd32: ch = 7'h64;
            6'd33: ch = 7'h66;
            6'd34: ch = 7'h67;
            6'd35: ch = 7'h68;
            6'd36: ch = 7'h6A;
            6'd37: ch = 7'h6B;
            6'd38: ch = 7'h6C;
            6'd39: ch = 7'h3B;
            6'd40: ch = 7'h27;
            6'd41: ch = 7'h60;
            6'd43: ch = 7'h5C;
            6'd44: ch = 7'h7A;
            6'd45: ch = 7'h78;
            6'd46: ch = 7'h63;
            6'd47: ch = 7'h76;
            6'd48: ch = 7'h62;
            6'd49: ch = 7'h6E;
            6'd50: ch = 7'h6D;
            6'd51: ch = 7'h2C;
            6'd52: ch = 7'h2E;
            6'd53: ch = 7'h2F;
            6'd57: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/kle_if.sv
// Valid/ready channel interfaces of the keyboard line editor.
`default_nettype none

interface kle_key_if import kle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

interface kle_res_if import kle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output kind, output character, output last, input ready);
    modport sink   (input valid, input kind, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/keyboard_scancode_line_editor.sv
// Top level of the keyboard scan code line editor.
//
//   Channel   Direction  Payload                      Handshake
//   i_key     in         scan_code[7:0]               valid/ready, taken when both high
//   o_res     out        kind[1:0] character[6:0] last valid/ready, taken when both high
//
// A plain key, backspace, caps lock or an ignored code is handled in the cycle it is
// accepted. Enter gives a newline, one result per stored character and a closing
// newline, so it occupies the block until the closing newline is registered; while the
// sink is ready, the rate is set by the single read port of the line memory, one entry
// per cycle. Stalls on the result side hold the result register and pause the line walk.
// Reset is synchronous; the line memory is not cleared, since only entries below the
// stored length are ever read, and those have been written.
`default_nettype none

module keyboard_scancode_line_editor import kle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kle_key_if.sink   i_key,
    kle_res_if.source o_res
);

    // Memory request and read data between the sequencer and the line store.
    // Writes happen only while idle and reads only when enter is taken and during the
    // walk, so the two never touch the same entry in overlapping cycles.
    t_mem_req          mem_req;
    logic [CHAR_W-1:0] rd_data;

    kle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_key),
        .o_res     (o_res),
        .o_mem_req (mem_req),
        .i_rd_data (rd_data)
    );

    kle_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

FILE: hdl/kle_line_mem.sv
// Line store: one write port and one read port with registered read data.
`default_nettype none

module kle_line_mem import kle_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_mem_req          i_req,
    output logic      [CHAR_W-1:0] o_rd_data
);

    logic [CHAR_W-1:0] r_mem [LINE_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/kle_ctrl.sv
// Sequencer of the line editor: decodes items, updates the line and drives the result register.
`default_nettype none

module kle_ctrl import kle_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    kle_key_if.sink                i_key,
    kle_res_if.source              o_res,
    output t_mem_req               o_mem_req,
    input  wire logic [CHAR_W-1:0] i_rd_data
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_CLOSE} t_state;

    t_state            r_state, n_state;
    logic              r_caps, n_caps;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;

    logic              slot_free;
    logic              key_take;
    logic [CHAR_W-1:0] key_raw;
    logic [CHAR_W-1:0] key_ch;
    logic [LEN_W-1:0]  idx_ext;
    t_mem_req          mem_req;

    // The result register frees up in the same cycle the sink takes its item.
    assign slot_free   = !r_out_valid || o_res.ready;
    assign i_key.ready = (r_state == S_IDLE) && slot_free;
    assign key_take    = i_key.valid && i_key.ready;

    assign key_raw = us_key(i_key.scan_code[5:0]);
    assign key_ch  = (r_caps && key_raw >= CHAR_LOW_A && key_raw <= CHAR_LOW_Z)
                   ? key_raw - CASE_GAP : key_raw;
    assign idx_ext = LEN_W'(r_idx) + LEN_W'(1);

    always_comb begin
        n_state     = r_state;
        n_caps      = r_caps;
        n_len       = r_len;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_char      = r_char;
        n_last      = r_last;
        mem_req     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (key_take) begin
                    priority if (i_key.scan_code == CODE_CAPS) begin
                        n_caps = !r_caps;
                    end else if (i_key.scan_code == CODE_BKSP) begin
                        if (r_len != '0) begin
                            n_len = r_len - 1'b1;
                        end
                        n_out_valid = 1'b1;
                        n_kind      = KIND_BKSP;
                        n_char      = '0;
                        n_last      = 1'b1;
                    end else if (i_key.scan_code == CODE_ENTER) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_NEWLINE;
                        n_char      = '0;
                        n_last      = 1'b0;
                        if (r_len == '0) begin
                            n_state = S_CLOSE;
                        end else begin
                            n_idx         = '0;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = '0;
                            n_state       = S_WALK;
                        end
                    end else if (i_key.scan_code > CODE_MAX) begin
                        n_state = S_IDLE;
                    end else begin
                        // A full line keeps its length and overwrites its last slot.
                        mem_req.we    = 1'b1;
                        mem_req.wdata = key_ch;
                        if (r_len < LEN_W'(LINE_DEPTH)) begin
                            mem_req.waddr = r_len[ADDR_W-1:0];
                            n_len         = r_len + 1'b1;
                        end else begin
                            mem_req.waddr = ADDR_W'(LINE_DEPTH - 1);
                        end
                        n_out_valid = 1'b1;
                        n_kind      = KIND_ECHO;
                        n_char      = key_ch;
                        n_last      = 1'b1;
                    end
                end
            end
            S_WALK: begin
                // Read data for r_idx is held until it has been moved to the result register.
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_STORED;
                    n_char      = i_rd_data;
                    n_last      = 1'b0;
                    if (idx_ext == r_len) begin
                        n_state = S_CLOSE;
                    end else begin
                        n_idx         = idx_ext[ADDR_W-1:0];
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_ext[ADDR_W-1:0];
                    end
                end
            end
            S_CLOSE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_NEWLINE;
                    n_char      = '0;
                    n_last      = 1'b1;
                    n_len       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_caps      <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_caps      <= n_caps;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_kind;
    assign o_res.character = r_char;
    assign o_res.last      = r_last;
    assign o_mem_req       = mem_req;

endmodule

`default_nettype wire

FILE: hdl/kle_checker.sv
// Port-level assertions of the keyboard line editor and their bind to the top level.
`default_nettype none

`include "keyboard_scancode_line_editor_defines.svh"

module kle_checker import kle_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_key_valid,
    input wire logic              i_key_ready,
    input wire logic              i_res_valid,
    input wire logic              i_res_ready,
    input wire logic [KIND_W-1:0] i_res_kind,
    input wire logic [CHAR_W-1:0] i_res_character,
    input wire logic              i_res_last
);

    `KLE_ASSERT(a_res_hold, (i_res_valid && !i_res_ready) |=> i_res_valid, "result item dropped while stalled")
    `KLE_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !i_res_valid, "result valid after reset")
    `KLE_ASSERT(a_no_take_when_blocked, (i_res_valid && !i_res_ready) |-> !i_key_ready, "key taken while result blocked")
    `KLE_ASSERT(a_busy_in_line, (i_res_valid && i_res_kind == KIND_NEWLINE && !i_res_last) |-> !i_key_ready, "key taken during a line dump")
    `KLE_ASSERT(a_zero_char, (i_res_valid && (i_res_kind == KIND_BKSP || i_res_kind == KIND_NEWLINE)) |-> (i_res_character == '0), "nonzero character on control result")

endmodule

bind keyboard_scancode_line_editor kle_checker u_kle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_key_valid     (i_key.valid),
    .i_key_ready     (i_key.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_kind      (o_res.kind),
    .i_res_character (o_res.character),
    .i_res_last      (o_res.last)
);

`default_nettype wire

FILE: tb/kle_echo_checker.sv
// Checker for the keyboard line editor: predicts the echo stream and compares each result.
`timescale 1ns / 1ps

module kle_echo_checker import kle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    kle_key_if   i_key,
    kle_res_if   i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_results
);

    localparam int KEY_COUNT = 58;
    // Make codes 0 to 57 of the US layout, one byte per code. Backspace and enter
    // never reach the table, so their slots hold a filler.
    localparam logic [8*KEY_COUNT-1:0] US_LAYOUT =
        "??1234567890-=~?qwertyuiop[]~?asdfghjkl;'`?\\zxcvbnm,./??? ";
    localparam int MAX_SHOWN = 30;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_echo;

    logic              caps_on_q;
    logic [CHAR_W-1:0] line_q [LINE_DEPTH];
    int                line_len;
    t_echo             echo_queue [$];
    int                shown;

    task automatic report_mismatch(input string what);
        if (shown < MAX_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, what);
        shown++;
        o_errors++;
    endtask

    task automatic predict_keystroke(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        if (code == CODE_CAPS) begin
            caps_on_q = !caps_on_q;
        end else if (code == CODE_BKSP) begin
            if (line_len > 0)
                line_len--;
            echo_queue.push_back(t_echo'{KIND_BKSP, '0, 1'b1});
        end else if (code == CODE_ENTER) begin
            echo_queue.push_back(t_echo'{KIND_NEWLINE, '0, 1'b0});
            for (int i = 0; i < line_len; i++)
                echo_queue.push_back(t_echo'{KIND_STORED, line_q[ADDR_W'(i)], 1'b0});
            echo_queue.push_back(t_echo'{KIND_NEWLINE, '0, 1'b1});
            line_len = 0;
        end else if (code <= CODE_MAX) begin
            ch = US_LAYOUT[8*(KEY_COUNT-1-int'(code)) +: CHAR_W];
            if (caps_on_q && ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z)
                ch = ch - CASE_GAP;
            // A full line keeps its length and overwrites its last character.
            if (line_len < LINE_DEPTH) begin
                line_q[ADDR_W'(line_len)] = ch;
                line_len++;
            end else begin
                line_q[ADDR_W'(LINE_DEPTH-1)] = ch;
            end
            echo_queue.push_back(t_echo'{KIND_ECHO, ch, 1'b1});
        end
    endtask

    always @(posedge i_clk) begin
        t_echo want;
        if (!i_rst_n) begin
            caps_on_q = 1'b0;
            line_len  = 0;
            echo_queue.delete();
        end else begin
            if (i_key.valid && i_key.ready)
                predict_keystroke(i_key.scan_code);
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (echo_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d char %02h last %0d",
                        i_res.kind, i_res.character, i_res.last));
                end else begin
                    want = echo_queue.pop_front();
                    if (i_res.kind !== want.kind)
                        report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                            o_results, i_res.kind, want.kind));
                    if (i_res.character !== want.character)
                        report_mismatch($sformatf("result %0d char %02h, expected %02h",
                            o_results, i_res.character, want.character));
                    if (i_res.last !== want.last)
                        report_mismatch($sformatf("result %0d last %0d, expected %0d",
                            o_results, i_res.last, want.last));
                end
            end
        end
        o_pending = echo_queue.size();
    end

endmodule

FILE: tb/keyboard_scancode_line_editor_test.sv
// Top of the keyboard line editor testbench: clock, reset, key stimulus and verdict.
`timescale 1ns / 1ps

module keyboard_scancode_line_editor_test import kle_pkg::*;;

    // The random part stops once this many scan codes in all were sent.
    localparam int RANDOM_ITEMS = 130;
    // From this point on neither side idles, so the tail runs at full rate.
    localparam int CALM_FROM    = 110;
    // Cycles in a row with no item moving on either channel before giving up. The
    // slowest correct stretch is a sender gap or a result stall.
    localparam int IDLE_LIMIT   = 2000;
    // Enter walks up to LINE_DEPTH entries, so this covers any work still in flight.
    localparam int DRAIN_CYCLES = LINE_DEPTH + 8;

    // Opening keys: backspace and enter on an empty line, the keys that translate
    // to a question mark, both ends of the table, letters and a symbol under caps
    // lock, ignored codes with the top bit set and clear, then a final edit.
    localparam int OPENING_COUNT = 25;
    localparam logic [CODE_W*OPENING_COUNT-1:0] OPENING_KEYS = {
        CODE_BKSP, CODE_ENTER, 8'd0, 8'd1, 8'd15, 8'd29, 8'd42, 8'd54, 8'd55,
        8'd56, 8'd57, 8'd2, 8'd13, CODE_CAPS, 8'd30, 8'd44, 8'd26, CODE_CAPS,
        8'd16, 8'd59, 8'h80, 8'hFF, CODE_BKSP, 8'd41, CODE_ENTER
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kle_key_if key_ch ();
    kle_res_if res_ch ();

    int errors;
    int pending;
    int results;

    // Stimulus controls shared with the result-side stall generator.
    logic lull_ok = 1'b0;   // idling allowed in the current stretch
    logic calm    = 1'b0;   // last part of the run: no idling at all
    int   stall_left = 0;
    int   idle_cycles = 0;

    // Tallies for the closing summary.
    int sent_count   = 0;
    int n_enter      = 0;
    int n_bksp       = 0;
    int n_caps       = 0;
    int n_ignored    = 0;
    int n_chars      = 0;

    keyboard_scancode_line_editor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_ch),
        .o_res   (res_ch)
    );

    kle_echo_checker echo_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (key_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_results (results)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        key_ch.valid     = 1'b0;
        key_ch.scan_code = '0;
        res_ch.ready     = 1'b0;
    end

    // Result side: ready drops in random bursts while idling is allowed, and otherwise
    // stays high.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (i_rst_n && lull_ok && !calm && $urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Presents one scan code and holds it until the block takes it. Called at a
    // falling edge and returns at one. An optional gap with valid low goes ahead
    // of the item; valid otherwise stays high between items.
    task automatic send_code(input logic [CODE_W-1:0] code);
        int gap;
        if (lull_ok && !calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            key_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        key_ch.valid     <= 1'b1;
        key_ch.scan_code <= code;
        @(posedge i_clk);
        while (!key_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        if (code == CODE_ENTER)
            n_enter++;
        else if (code == CODE_BKSP)
            n_bksp++;
        else if (code == CODE_CAPS)
            n_caps++;
        else if (code > CODE_MAX)
            n_ignored++;
        else
            n_chars++;
        sent_count++;
    endtask

    // Types one line of printable keys and closes it with enter. With editing on,
    // backspaces, caps lock toggles and stray codes above the key table are mixed in.
    task automatic type_line(input int len, input bit edits);
        logic [CODE_W-1:0] code;
        int pick;
        for (int k = 0; k < len; k++) begin
            pick = edits ? $urandom_range(0, 15) : 15;
            if (pick < 2) begin
                send_code(CODE_BKSP);
            end else if (pick == 2) begin
                send_code(CODE_CAPS);
            end else if (pick == 3) begin
                send_code(CODE_W'($urandom_range(CODE_MAX + 1, 255)));
            end else begin
                code = CODE_W'($urandom_range(0, CODE_MAX));
                while (code == CODE_BKSP || code == CODE_ENTER)
                    code = CODE_W'($urandom_range(0, CODE_MAX));
                send_code(code);
            end
        end
        send_code(CODE_ENTER);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < OPENING_COUNT; i++)
            send_code(OPENING_KEYS[CODE_W*(OPENING_COUNT-1-i) +: CODE_W]);

        // The first random line runs past the end of the store without edits, so
        // the overwrite of the last slot and a full-length enter are always seen.
        lull_ok = 1'b1;
        type_line(LINE_DEPTH + 4, 1'b0);

        // Mostly well-formed lines of random content; some raw codes in between, which
        // are drawn from the whole range of the byte, so release codes can occur.
        while (sent_count < RANDOM_ITEMS) begin
            calm    = (sent_count >= CALM_FROM);
            lull_ok = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
                send_code(CODE_W'($urandom_range(0, 255)));
            else if ($urandom_range(0, 9) == 0)
                type_line($urandom_range(LINE_DEPTH - 2, LINE_DEPTH + 6), 1'b1);
            else
                type_line($urandom_range(0, 10), 1'b1);
        end

        calm = 1'b1;
        key_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d scan codes: %0d characters, %0d backspaces, %0d enters,",
            n_chars + n_bksp + n_enter + n_caps + n_ignored, n_chars, n_bksp, n_enter);
        $display("%0d caps lock toggles and %0d ignored codes; %0d results checked.",
            n_caps, n_ignored, results);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/kle_pkg.sv
hdl/kle_if.sv
hdl/kle_line_mem.sv
hdl/kle_ctrl.sv
hdl/keyboard_scancode_line_editor.sv
hdl/kle_checker.sv
tb/kle_echo_checker.sv
tb/keyboard_scancode_line_editor_test.sv
